### design/prtjs_pkg.sv
// prtjs_pkg: shared types and constants for the pendant report to jog signals block
// holds the item and result beat structs, button codes and action line positions
// no dependencies
package prtjs_pkg;

	// accumulator and threshold widths
	localparam int ACC_WIDTH = 24;
	localparam int THR_WIDTH = 24;
	localparam int LIM_WIDTH = (ACC_WIDTH > THR_WIDTH) ? ACC_WIDTH : THR_WIDTH;

	// button codes
	localparam logic [7:0] BTN_NONE         = 8'h00;
	localparam logic [7:0] BTN_STOP         = 8'h02;
	localparam logic [7:0] BTN_START_PAUSE  = 8'h03;
	localparam logic [7:0] BTN_MACHINE_HOME = 8'h08;
	localparam logic [7:0] BTN_WORK_HOME    = 8'h0a;
	localparam logic [7:0] BTN_CONTINUOUS   = 8'h0e;
	localparam logic [7:0] BTN_STEP         = 8'h0f;
	localparam logic [7:0] BTN_MACRO_TEN    = 8'h10;

	// feed and axis selector codes
	localparam logic [7:0] FEED_FIRST = 8'h0e;
	localparam logic [7:0] FEED_LAST  = 8'h10;
	localparam logic [7:0] AXIS_FIRST = 8'h11;
	localparam logic [7:0] AXIS_LAST  = 8'h14;
	localparam logic [7:0] AXIS_OFF   = 8'h06;

	// wheel byte decode
	localparam logic [7:0] WHEEL_FWD_MAX = 8'd128;
	localparam logic [7:0] WHEEL_TOP     = 8'd255;

	// item kinds
	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// action line bit positions
	localparam int LINE_STOP    = 0;
	localparam int LINE_START   = 1;
	localparam int LINE_PARK    = 2;
	localparam int LINE_HOME    = 3;
	localparam int LINE_HOME_IN = 4;
	localparam int LINE_COUNT   = 5;

	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1000);

	typedef struct packed {
		logic       func;
		logic [7:0] button_code;
		logic [7:0] feed_code;
		logic [7:0] axis_code;
		logic [7:0] wheel_delta;
	} item_t;

	typedef struct packed {
		logic       estop_line;
		logic [3:0] axis_select;
		logic       continuous_line;
		logic [2:0] resolution_select;
		logic       cycle_stop_line;
		logic       cycle_start_line;
		logic       parking_line;
		logic       home_line;
		logic       home_input_line;
		logic       quad_a;
		logic       quad_b;
	} result_t;

endpackage

### design/pendant_report_to_jog_signals_top.sv
// Usage:
//   item channel (item_valid/item_ready/item) takes one beat per pendant report
//   (func 0) or per time tick (func 1). Every accepted beat produces exactly one
//   result beat on result_valid/result_ready/result, showing all control lines
//   and the emulated encoder levels after that beat's update.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes step_threshold; it is
//   always ready; the user must write it only while no beat is in flight, the block does not enforce this.
// Result: the result register loads on the accept edge.
// Throughput: one beat per cycle while result_ready is high; the report decode and the single accumulator
//   add/subtract/compare sit between the state registers and the result register.
// Reset: all latches clear, axis off, feed at the first resolution, encoder
//   phase and accumulator zero, threshold 1000; no result beat is pending.
// Stall: while a result waits and result_ready is low, item_ready drops; when
//   result_ready is high a new beat is taken in the same cycle the result leaves.
// Depends on prtjs_pkg.
module pendant_report_to_jog_signals_top
	import prtjs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [THR_WIDTH-1:0] cfg_data
);

	// state registers
	logic [THR_WIDTH-1:0]  threshold_q;
	logic                  continuous_q;
	logic [7:0]            feed_q;
	logic [7:0]            axis_q;
	logic [7:0]            prev_btn_q;
	logic                  hold_q;
	logic                  estop_q;
	logic [7:0]            wheel_q;
	logic [LINE_COUNT-1:0] action_q;
	logic [1:0]            phase_q;
	logic [ACC_WIDTH-1:0]  acc_q;
	logic                  result_valid_q;
	result_t               result_q;

	// next state
	logic                  continuous_d;
	logic [7:0]            feed_d;
	logic [7:0]            axis_d;
	logic [7:0]            prev_btn_d;
	logic                  hold_d;
	logic                  estop_d;
	logic [7:0]            wheel_d;
	logic [LINE_COUNT-1:0] action_d;
	logic [1:0]            phase_d;
	logic [ACC_WIDTH-1:0]  acc_d;
	result_t               result_d;

	logic                  accept;
	logic                  fresh;
	logic                  forward;
	logic [7:0]            speed;
	logic [LIM_WIDTH-1:0]  thr_ext;
	logic [LIM_WIDTH-1:0]  top_ext;
	logic [ACC_WIDTH-1:0]  limit;
	logic [ACC_WIDTH:0]    sum;
	logic [ACC_WIDTH:0]    rem;
	logic [ACC_WIDTH:0]    limit_ext;

	assign cfg_ready    = 1'b1;
	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// threshold limited to the accumulator range
	assign thr_ext   = LIM_WIDTH'(threshold_q);
	assign top_ext   = LIM_WIDTH'({ACC_WIDTH{1'b1}});
	assign limit     = (thr_ext < top_ext) ? thr_ext[ACC_WIDTH-1:0] : top_ext[ACC_WIDTH-1:0];
	assign limit_ext = {1'b0, limit};

	// wheel speed and direction from the stored wheel byte
	assign forward = (wheel_q <= WHEEL_FWD_MAX);
	assign speed   = forward ? wheel_q : (WHEEL_TOP - wheel_q);
	assign sum     = {1'b0, acc_q} + (ACC_WIDTH + 1)'(speed);
	assign fresh   = (prev_btn_q == BTN_NONE);

	// update for one beat
	always_comb begin
		continuous_d = continuous_q;
		feed_d       = feed_q;
		axis_d       = axis_q;
		prev_btn_d   = prev_btn_q;
		hold_d       = hold_q;
		estop_d      = estop_q;
		wheel_d      = wheel_q;
		action_d     = action_q;
		phase_d      = phase_q;
		acc_d        = acc_q;
		rem          = sum;
		if (item.func == FUNC_TICK) begin
			// phase accumulator step
			if (speed == 8'd0) begin
				phase_d = 2'd0;
				acc_d   = '0;
			end else begin
				if (sum >= limit_ext) begin
					rem = sum - limit_ext;
					if (rem >= limit_ext) begin
						rem = limit_ext;
					end
					phase_d = phase_q + (forward ? 2'd1 : 2'd3);
				end
				acc_d = rem[ACC_WIDTH-1:0];
			end
		end else begin
			// report decode
			priority if (item.button_code == BTN_STOP && fresh) begin
				estop_d = !estop_q;
			end else if (item.button_code == BTN_START_PAUSE && fresh) begin
				hold_d = !hold_q;
			end else if (item.button_code == BTN_CONTINUOUS) begin
				continuous_d = 1'b1;
			end else if (item.button_code == BTN_STEP) begin
				continuous_d = 1'b0;
			end else begin
				// other codes leave toggles and jog mode alone
				continuous_d = continuous_q;
			end
			feed_d     = item.feed_code;
			axis_d     = item.axis_code;
			prev_btn_d = item.button_code;
			wheel_d    = item.wheel_delta;
			// action lines, held for other buttons
			unique case (item.button_code)
				BTN_START_PAUSE: begin
					action_d = '0;
					action_d[LINE_STOP]  = hold_d;
					action_d[LINE_START] = !hold_d;
				end
				BTN_WORK_HOME: begin
					action_d = '0;
					action_d[LINE_PARK] = 1'b1;
				end
				BTN_MACHINE_HOME: begin
					action_d = '0;
					action_d[LINE_HOME] = 1'b1;
				end
				BTN_MACRO_TEN: begin
					action_d = '0;
					action_d[LINE_HOME_IN] = 1'b1;
				end
				BTN_NONE: begin
					action_d = '0;
				end
				default: begin
					action_d = action_q;
				end
			endcase
		end
	end

	// result from the updated state
	always_comb begin
		result_d                   = '0;
		result_d.estop_line        = !estop_d;
		result_d.continuous_line   = continuous_d;
		if (axis_d >= AXIS_FIRST && axis_d <= AXIS_LAST) begin
			result_d.axis_select = 4'b0001 << (axis_d[1:0] - AXIS_FIRST[1:0]);
		end
		if (feed_d >= FEED_FIRST && feed_d <= FEED_LAST) begin
			result_d.resolution_select = 3'b001 << (feed_d[1:0] - FEED_FIRST[1:0]);
		end
		result_d.cycle_stop_line   = action_d[LINE_STOP];
		result_d.cycle_start_line  = action_d[LINE_START];
		result_d.parking_line      = action_d[LINE_PARK];
		result_d.home_line         = action_d[LINE_HOME];
		result_d.home_input_line   = action_d[LINE_HOME_IN];
		result_d.quad_a            = (phase_d == 2'd1) || (phase_d == 2'd2);
		result_d.quad_b            = phase_d[1];
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	// jog state, loaded on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			continuous_q <= 1'b0;
			feed_q       <= FEED_FIRST;
			axis_q       <= AXIS_OFF;
			prev_btn_q   <= BTN_NONE;
			hold_q       <= 1'b0;
			estop_q      <= 1'b0;
			wheel_q      <= 8'd0;
			action_q     <= '0;
			phase_q      <= 2'd0;
			acc_q        <= '0;
		end else if (accept) begin
			continuous_q <= continuous_d;
			feed_q       <= feed_d;
			axis_q       <= axis_d;
			prev_btn_q   <= prev_btn_d;
			hold_q       <= hold_d;
			estop_q      <= estop_d;
			wheel_q      <= wheel_d;
			action_q     <= action_d;
			phase_q      <= phase_d;
			acc_q        <= acc_d;
		end
	end

	// result beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

`ifndef ASSERT_OFF
	// every accepted beat shows up as a pending result next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted beat produced no result");

	// the item side only stalls behind a waiting result
	a_stall_only_on_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid_q && !result_ready))
		else $error("item channel stalled without a pending result");

	// ticks never touch the e-stop latch or the jog mode
	a_tick_keeps_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.func == FUNC_TICK) |=>
			(estop_q == $past(estop_q) && continuous_q == $past(continuous_q)))
		else $error("tick changed a report latch");

	// accumulator stays within its range after a stepped tick
	a_acc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.func == FUNC_TICK) |=> ({1'b0, acc_q} <= $past(limit_ext)
			|| $past(acc_q) >= $past(limit)))
		else $error("accumulator above threshold");
`endif

endmodule

### bench/tb_pendant_report_to_jog_signals_top.sv
// tb_pendant_report_to_jog_signals_top: self-checking bench for the pendant to jog signals block
// drives report and tick beats and step_threshold writes, and predicts every result beat
// depends on prtjs_pkg and pendant_report_to_jog_signals_top
`timescale 1ns / 100ps

module tb_pendant_report_to_jog_signals_top;
	import prtjs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid;
	logic                 item_ready;
	item_t                item;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [THR_WIDTH-1:0] cfg_data;

	// expected line states, oldest first
	result_t pending_lines[$];
	int      mismatch_count = 0;
	int      cycle_count = 0;

	// idle shaping, changed per phase
	int tx_gap_max = 0;
	int rx_gap_max = 0;
	int rx_hold_cycles = 0;

	// shadow state of the jog logic
	logic [THR_WIDTH-1:0]  model_threshold;
	logic                  model_continuous;
	logic [7:0]            model_feed;
	logic [7:0]            model_axis;
	logic [7:0]            model_prev_button;
	logic                  model_hold;
	logic                  model_estop;
	logic [7:0]            model_wheel;
	logic [LINE_COUNT-1:0] model_actions;
	logic [1:0]            model_phase;
	logic [63:0]           model_acc;

	pendant_report_to_jog_signals_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// advance the shadow state by one beat and return the lines it shows
	task automatic advance_jog_model(input item_t it, output result_t lines);
		logic        forward;
		logic [7:0]  speed;
		logic [63:0] sum;
		logic [63:0] limit;
		logic        fresh;
		begin
			if (it.func == FUNC_TICK) begin
				forward = model_wheel <= WHEEL_FWD_MAX;
				speed = forward ? model_wheel : WHEEL_TOP - model_wheel;
				if (speed == 8'd0) begin
					model_phase = 2'd0;
					model_acc = '0;
				end else begin
					limit = (64'd1 << ACC_WIDTH) - 64'd1;
					if (64'(model_threshold) < limit)
						limit = 64'(model_threshold);
					sum = model_acc + 64'(speed);
					if (sum >= limit) begin
						sum = sum - limit;
						if (sum >= limit)
							sum = limit;
						model_phase = model_phase + (forward ? 2'd1 : 2'd3);
					end
					model_acc = sum;
				end
			end else begin
				// toggles only on a fresh press
				fresh = model_prev_button == BTN_NONE;
				if (it.button_code == BTN_STOP && fresh)
					model_estop = ~model_estop;
				else if (it.button_code == BTN_START_PAUSE && fresh)
					model_hold = ~model_hold;
				else if (it.button_code == BTN_CONTINUOUS)
					model_continuous = 1'b1;
				else if (it.button_code == BTN_STEP)
					model_continuous = 1'b0;
				model_feed = it.feed_code;
				model_axis = it.axis_code;
				model_prev_button = it.button_code;
				model_wheel = it.wheel_delta;
				// action lines, held for unlisted codes
				case (it.button_code)
					BTN_START_PAUSE: begin
						model_actions = '0;
						if (model_hold)
							model_actions[LINE_STOP] = 1'b1;
						else
							model_actions[LINE_START] = 1'b1;
					end
					BTN_WORK_HOME: begin
						model_actions = '0;
						model_actions[LINE_PARK] = 1'b1;
					end
					BTN_MACHINE_HOME: begin
						model_actions = '0;
						model_actions[LINE_HOME] = 1'b1;
					end
					BTN_MACRO_TEN: begin
						model_actions = '0;
						model_actions[LINE_HOME_IN] = 1'b1;
					end
					BTN_NONE: begin
						model_actions = '0;
					end
					default: begin
					end
				endcase
			end
			lines = '0;
			lines.estop_line = ~model_estop;
			if (model_axis >= AXIS_FIRST && model_axis <= AXIS_LAST)
				lines.axis_select = 4'(1 << (model_axis - AXIS_FIRST));
			lines.continuous_line = model_continuous;
			if (model_feed >= FEED_FIRST && model_feed <= FEED_LAST)
				lines.resolution_select = 3'(1 << (model_feed - FEED_FIRST));
			lines.cycle_stop_line = model_actions[LINE_STOP];
			lines.cycle_start_line = model_actions[LINE_START];
			lines.parking_line = model_actions[LINE_PARK];
			lines.home_line = model_actions[LINE_HOME];
			lines.home_input_line = model_actions[LINE_HOME_IN];
			lines.quad_a = (model_phase == 2'd1) || (model_phase == 2'd2);
			lines.quad_b = model_phase >= 2'd2;
		end
	endtask

	task automatic compare_line(input string name, input int want, input int got);
		begin
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatch_count++;
			end
		end
	endtask

	task automatic check_jog_lines(input result_t want, input result_t got);
		begin
			compare_line("estop_line", want.estop_line, got.estop_line);
			compare_line("axis_select", want.axis_select, got.axis_select);
			compare_line("continuous_line", want.continuous_line, got.continuous_line);
			compare_line("resolution_select", want.resolution_select, got.resolution_select);
			compare_line("cycle_stop_line", want.cycle_stop_line, got.cycle_stop_line);
			compare_line("cycle_start_line", want.cycle_start_line, got.cycle_start_line);
			compare_line("parking_line", want.parking_line, got.parking_line);
			compare_line("home_line", want.home_line, got.home_line);
			compare_line("home_input_line", want.home_input_line, got.home_input_line);
			compare_line("quad_a", want.quad_a, got.quad_a);
			compare_line("quad_b", want.quad_b, got.quad_b);
		end
	endtask

	// result checker, one beat per handshake
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_lines.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, result);
				mismatch_count++;
			end else begin
				check_jog_lines(pending_lines.pop_front(), result);
			end
		end
	end

	// result sink with random stalls and one long hold-off on request
	initial begin : result_sink
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = $urandom_range(rx_gap_max, 0);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// offer one beat after a random gap; valid stays up into the next beat when no gap
	task automatic offer_pendant_beat(input item_t it);
		int      gap;
		result_t want;
		begin
			gap = $urandom_range(tx_gap_max, 0);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_valid <= 1'b1;
			item <= it;
			@(posedge clk);
			while (!item_ready) @(posedge clk);
			advance_jog_model(it, want);
			pending_lines.push_back(want);
		end
	endtask

	// drop valid and wait for every expected beat to come back
	task automatic settle_jog_block();
		begin
			item_valid <= 1'b0;
			while (pending_lines.size() != 0) @(posedge clk);
			repeat (2) @(posedge clk);
		end
	endtask

	task automatic write_step_threshold(input logic [THR_WIDTH-1:0] value);
		begin
			cfg_valid <= 1'b1;
			cfg_data <= value;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			model_threshold = value;
			cfg_valid <= 1'b0;
		end
	endtask

	function automatic item_t pendant_report(input logic [7:0] button, input logic [7:0] feed,
		input logic [7:0] axis, input logic [7:0] wheel);
		item_t it;
		it.func = FUNC_REPORT;
		it.button_code = button;
		it.feed_code = feed;
		it.axis_code = axis;
		it.wheel_delta = wheel;
		return it;
	endfunction

	// tick with junk in the fields it ignores
	function automatic item_t timer_tick();
		item_t it;
		it = item_t'($urandom());
		it.func = FUNC_TICK;
		return it;
	endfunction

	// mostly meaningful codes, some raw bytes
	function automatic item_t random_pendant_beat();
		item_t it;
		it = item_t'($urandom());
		it.func = ($urandom_range(99) < 55) ? FUNC_TICK : FUNC_REPORT;
		if (it.func == FUNC_REPORT) begin
			case ($urandom_range(11))
				0, 1, 2: it.button_code = BTN_NONE;
				3:       it.button_code = BTN_STOP;
				4:       it.button_code = BTN_START_PAUSE;
				5:       it.button_code = BTN_MACHINE_HOME;
				6:       it.button_code = BTN_WORK_HOME;
				7:       it.button_code = BTN_CONTINUOUS;
				8:       it.button_code = BTN_STEP;
				9:       it.button_code = BTN_MACRO_TEN;
				default: begin
				end
			endcase
			if ($urandom_range(3) != 0)
				it.feed_code = FEED_FIRST + 8'($urandom_range(2));
			if ($urandom_range(3) != 0)
				it.axis_code = AXIS_FIRST + 8'($urandom_range(3));
			case ($urandom_range(7))
				0:       it.wheel_delta = WHEEL_FWD_MAX;
				1:       it.wheel_delta = WHEEL_TOP;
				2:       it.wheel_delta = 8'd0;
				3:       it.wheel_delta = WHEEL_FWD_MAX + 8'd1;
				default: begin
				end
			endcase
		end
		return it;
	endfunction

	// reset state, fresh and held presses, action lines, axis and feed decode
	task automatic test_reset_and_buttons();
		begin
			tx_gap_max = 3;
			rx_gap_max = 3;
			offer_pendant_beat(timer_tick());
			offer_pendant_beat(pendant_report(BTN_STOP, 8'h0e, 8'h11, 8'd0));
			offer_pendant_beat(pendant_report(BTN_STOP, 8'h0f, 8'h12, 8'd0));
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h10, 8'h13, 8'd0));
			offer_pendant_beat(pendant_report(BTN_STOP, 8'h10, 8'h14, 8'd0));
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h0d, 8'h10, 8'd0));
			offer_pendant_beat(pendant_report(BTN_START_PAUSE, 8'h11, 8'h15, 8'd0));
			offer_pendant_beat(pendant_report(BTN_START_PAUSE, 8'h0e, 8'h11, 8'd0));
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h00, 8'h00, 8'd0));
			offer_pendant_beat(pendant_report(BTN_START_PAUSE, 8'hff, 8'hff, 8'd0));
			offer_pendant_beat(pendant_report(8'hff, 8'h0f, 8'h12, 8'd0));
			offer_pendant_beat(pendant_report(BTN_WORK_HOME, 8'h0f, 8'h12, 8'd0));
			offer_pendant_beat(pendant_report(BTN_MACHINE_HOME, 8'h0e, 8'h13, 8'd0));
			offer_pendant_beat(pendant_report(BTN_MACRO_TEN, 8'h10, 8'h14, 8'd0));
			offer_pendant_beat(pendant_report(BTN_CONTINUOUS, 8'h10, 8'h11, 8'd0));
			offer_pendant_beat(pendant_report(BTN_STEP, 8'h0e, 8'h11, 8'd0));
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h0e, 8'h06, 8'd0));
			settle_jog_block();
		end
	endtask

	// encoder edges at a threshold of 128, both directions, zero speed clear
	task automatic test_wheel_quadrature();
		begin
			write_step_threshold(THR_WIDTH'(128));
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h0e, 8'h11, WHEEL_FWD_MAX));
			repeat (3) offer_pendant_beat(timer_tick());
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h0e, 8'h11, WHEEL_FWD_MAX + 8'd1));
			repeat (2) offer_pendant_beat(timer_tick());
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h0e, 8'h11, WHEEL_TOP));
			offer_pendant_beat(timer_tick());
			offer_pendant_beat(pendant_report(BTN_NONE, 8'h0e, 8'h11, 8'd0));
			offer_pendant_beat(timer_tick());
			settle_jog_block();
		end
	endtask

	task automatic test_random_traffic(input logic [THR_WIDTH-1:0] threshold,
		input int tx_max, input int rx_max, input int count);
		begin
			write_step_threshold(threshold);
			tx_gap_max = tx_max;
			rx_gap_max = rx_max;
			repeat (count) offer_pendant_beat(random_pendant_beat());
			settle_jog_block();
		end
	endtask

	// long receiver hold-off while beats keep coming, input must stall
	task automatic test_result_backpressure();
		begin
			tx_gap_max = 0;
			rx_gap_max = 2;
			rx_hold_cycles = 250;
			repeat (30) offer_pendant_beat(random_pendant_beat());
			settle_jog_block();
		end
	endtask

	initial begin
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		model_threshold = THR_RESET;
		model_continuous = 1'b0;
		model_feed = FEED_FIRST;
		model_axis = AXIS_OFF;
		model_prev_button = BTN_NONE;
		model_hold = 1'b0;
		model_estop = 1'b0;
		model_wheel = 8'd0;
		model_actions = '0;
		model_phase = 2'd0;
		model_acc = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_buttons();
		test_wheel_quadrature();
		test_random_traffic(THR_WIDTH'(128), 16, 16, 130);
		test_random_traffic(THR_WIDTH'(300), 0, 0, 130);
		test_random_traffic({THR_WIDTH{1'b1}}, 0, 16, 130);
		test_random_traffic(THR_WIDTH'($urandom_range(2000, 128)), 16, 0, 130);
		test_random_traffic(THR_WIDTH'($urandom_range(16777215, 128)), 8, 8, 100);
		test_random_traffic(THR_WIDTH'(1000), 16, 16, 130);
		test_result_backpressure();

		settle_jog_block();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
design/prtjs_pkg.sv
design/pendant_report_to_jog_signals_top.sv
bench/tb_pendant_report_to_jog_signals_top.sv
